// ===== src/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes of the binary heap priority queue: commands,
// result status codes, controller states and the sift decision.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  // request commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // width of the count field in a result
  localparam int COUNT_W = 7;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CMP,
    S_POP_LAST,
    S_POP_CMP,
    S_DONE
  } state_t;

  // outcome of one level of the sift compare
  typedef struct packed {
    logic take_right;  // right child strictly precedes left child
    logic mov_first;   // moving entry strictly precedes the chosen entry
  } sift_dec_t;

endpackage

// ===== src/bhpq_in_if.sv =====
// ----------------------------------------------------------------------------
// bhpq_in_if
// Request channel of the priority queue: valid/ready handshake with a
// command, a signed key and a payload tag.
// ----------------------------------------------------------------------------
interface bhpq_in_if #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic signed [KEY_WIDTH-1:0]     key;
  logic        [PAYLOAD_WIDTH-1:0] payload;

  modport source (output valid, output cmd, output key, output payload, input ready);
  modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

// ===== src/bhpq_out_if.sv =====
// ----------------------------------------------------------------------------
// bhpq_out_if
// Result channel of the priority queue: valid/ready handshake with the
// popped entry, the new top entry, the entry count and a status code.
// ----------------------------------------------------------------------------
interface bhpq_out_if #(
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic                            popped_valid;
  logic signed [KEY_WIDTH-1:0]     popped_key;
  logic        [PAYLOAD_WIDTH-1:0] popped_payload;
  logic signed [KEY_WIDTH-1:0]     top_key;
  logic        [PAYLOAD_WIDTH-1:0] top_payload;
  logic        [6:0]               count;
  logic        [1:0]               status;

  modport source (output valid, output popped_valid, output popped_key,
                  output popped_payload, output top_key, output top_payload,
                  output count, output status, input ready);
  modport sink   (input valid, input popped_valid, input popped_key,
                  input popped_payload, input top_key, input top_payload,
                  input count, input status, output ready);
endinterface

// ===== src/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic synchronous RAM: one write port, two read ports, registered read
// data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/bhpq_sift.sv =====
// ----------------------------------------------------------------------------
// bhpq_sift
// One level of the sift compare. Picks the right child only when it strictly
// precedes the left one, then tells whether the moving entry strictly
// precedes the picked entry. Order is signed, smallest or largest first.
// ----------------------------------------------------------------------------
module bhpq_sift #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                  largest_first,
  input  logic [KEY_WIDTH-1:0]  mov_key,
  input  logic [KEY_WIDTH-1:0]  a_key,
  input  logic [KEY_WIDTH-1:0]  b_key,
  input  logic                  b_valid,
  output bhpq_pkg::sift_dec_t   dec
);

  logic [KEY_WIDTH-1:0] pick_key;

  // strict precedence in the selected signed order
  function automatic logic precedes(input logic lf, input logic [KEY_WIDTH-1:0] x,
                                    input logic [KEY_WIDTH-1:0] y);
    logic res;
    if (lf) begin
      res = $signed(x) > $signed(y);
    end else begin
      res = $signed(x) < $signed(y);
    end
    return res;
  endfunction

  // child selection, then moving entry against the chosen one
  always_comb begin
    dec.take_right = b_valid && precedes(largest_first, b_key, a_key);
    pick_key       = dec.take_right ? b_key : a_key;
    dec.mov_first  = precedes(largest_first, mov_key, pick_key);
  end

endmodule

// ===== src/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap of key/payload entries held in one RAM, with push and pop.
// ----------------------------------------------------------------------------
// One request is handled at a time; the next is taken as soon as the previous
// result sits in the output register. The entry moves at most log2(DEPTH)
// levels on a push and one less on a pop; a pop on an empty heap, a push on a
// full heap and a pop that empties the heap go straight to the result. The
// heap RAM has one write port and a registered read, so the sift advances one
// level per cycle: it reads the parent (push) or both children (pop), compares
// in the next cycle and writes the displaced entry into the hole, carrying the
// moving entry in a register until its final place is written. The root is
// mirrored in a register, so the popped entry and the new top need no read.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int DEPTH         = 64,
  parameter int KEY_WIDTH     = 32,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  bhpq_in_if.sink    in_ch,
  bhpq_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = CW + 1;
  localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

  bhpq_pkg::state_t  state_r, state_nxt;
  bhpq_pkg::status_t status_r, status_nxt;
  logic              largest_first_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     hole_r, hole_nxt;
  logic [EW-1:0]     mov_r, mov_nxt;
  logic [EW-1:0]     top_r, top_nxt;
  logic [EW-1:0]     popped_r, popped_nxt;
  logic              popv_r, popv_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_popv_r, out_popv_nxt;
  logic [EW-1:0]     out_popped_r, out_popped_nxt;
  logic [EW-1:0]     out_top_r, out_top_nxt;
  logic [6:0]        out_count_r, out_count_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [EW-1:0]     ram_wdata, ram_rdata_a, ram_rdata_b;

  logic              in_acc;
  logic [IW-1:0]     left_idx, right_idx, pick_idx, cnt_ext;
  logic              left_ok, right_ok;
  logic [AW-1:0]     parent_idx;
  logic [EW-1:0]     pick_data;
  logic [CW+6:0]     cnt_wide;
  bhpq_pkg::sift_dec_t dec;

  // heap storage
  bhpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // tree indices around the hole
  assign cnt_ext    = IW'(cnt_r);
  assign left_idx   = (IW'(hole_r) << 1) + IW'(1);
  assign right_idx  = (IW'(hole_r) << 1) + IW'(2);
  assign left_ok    = left_idx < cnt_ext;
  assign right_ok   = right_idx < cnt_ext;
  assign parent_idx = (hole_r - AW'(1)) >> 1;

  // compare unit, port a carries the parent on push and the left child on pop
  bhpq_sift #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_sift (
    .largest_first (largest_first_r),
    .mov_key       (mov_r[EW-1:PAYLOAD_WIDTH]),
    .a_key         (ram_rdata_a[EW-1:PAYLOAD_WIDTH]),
    .b_key         (ram_rdata_b[EW-1:PAYLOAD_WIDTH]),
    .b_valid       ((state_r == bhpq_pkg::S_POP_CMP) && right_ok),
    .dec           (dec)
  );

  assign pick_idx  = dec.take_right ? right_idx : left_idx;
  assign pick_data = dec.take_right ? ram_rdata_b : ram_rdata_a;

  // handshakes
  assign in_ch.ready = (state_r == bhpq_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cnt_wide    = {7'd0, cnt_r};

  // next state, datapath and RAM control
  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cnt_nxt        = cnt_r;
    hole_nxt       = hole_r;
    mov_nxt        = mov_r;
    popped_nxt     = popped_r;
    popv_nxt       = popv_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_popv_nxt   = out_popv_r;
    out_popped_nxt = out_popped_r;
    out_top_nxt    = out_top_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = hole_r;
    ram_wdata      = mov_r;
    ram_raddr_a    = parent_idx;
    ram_raddr_b    = AW'(right_idx);

    case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (in_acc) begin
          popv_nxt   = 1'b0;
          popped_nxt = '0;
          status_nxt = bhpq_pkg::STATUS_OK;
          if (in_ch.cmd == bhpq_pkg::CMD_PUSH) begin
            if (cnt_r == CW'(DEPTH)) begin
              status_nxt = bhpq_pkg::STATUS_FULL;
              state_nxt  = bhpq_pkg::S_DONE;
            end else begin
              // entry starts in the new last slot, its parent is fetched
              mov_nxt     = {in_ch.key, in_ch.payload};
              hole_nxt    = AW'(cnt_r);
              cnt_nxt     = cnt_r + CW'(1);
              ram_raddr_a = (AW'(cnt_r) - AW'(1)) >> 1;
              state_nxt   = bhpq_pkg::S_PUSH_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = bhpq_pkg::STATUS_EMPTY;
              state_nxt  = bhpq_pkg::S_DONE;
            end else begin
              // root leaves, last entry is fetched to refill it
              popv_nxt    = 1'b1;
              popped_nxt  = top_r;
              cnt_nxt     = cnt_r - CW'(1);
              ram_raddr_a = AW'(cnt_r - CW'(1));
              state_nxt   = (cnt_r == CW'(1)) ? bhpq_pkg::S_DONE : bhpq_pkg::S_POP_LAST;
            end
          end
        end
      end

      bhpq_pkg::S_PUSH_CMP: begin
        ram_we = 1'b1;
        if (hole_r != '0 && dec.mov_first) begin
          // parent moves down into the hole, hole climbs
          ram_wdata   = ram_rdata_a;
          hole_nxt    = parent_idx;
          ram_raddr_a = (parent_idx - AW'(1)) >> 1;
        end else begin
          state_nxt = bhpq_pkg::S_DONE;
        end
      end

      bhpq_pkg::S_POP_LAST: begin
        mov_nxt     = ram_rdata_a;
        hole_nxt    = '0;
        ram_raddr_a = AW'(1);
        ram_raddr_b = AW'(2);
        state_nxt   = bhpq_pkg::S_POP_CMP;
      end

      bhpq_pkg::S_POP_CMP: begin
        ram_we = 1'b1;
        if (left_ok && !dec.mov_first) begin
          // chosen child moves up into the hole, hole descends
          ram_wdata   = pick_data;
          hole_nxt    = AW'(pick_idx);
          ram_raddr_a = AW'((pick_idx << 1) + IW'(1));
          ram_raddr_b = AW'((pick_idx << 1) + IW'(2));
        end else begin
          state_nxt = bhpq_pkg::S_DONE;
        end
      end

      bhpq_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_popv_nxt   = popv_r;
          out_popped_nxt = popped_r;
          out_top_nxt    = (cnt_r != '0) ? top_r : '0;
          out_count_nxt  = cnt_wide[6:0];
          out_status_nxt = status_r;
          state_nxt      = bhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  // root mirror follows every write to the root slot
  assign top_nxt = (ram_we && ram_waddr == '0) ? ram_wdata : top_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= bhpq_pkg::S_IDLE;
      cnt_r           <= '0;
      largest_first_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        largest_first_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    hole_r       <= hole_nxt;
    mov_r        <= mov_nxt;
    top_r        <= top_nxt;
    popped_r     <= popped_nxt;
    popv_r       <= popv_nxt;
    out_popv_r   <= out_popv_nxt;
    out_popped_r <= out_popped_nxt;
    out_top_r    <= out_top_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.popped_valid   = out_popv_r;
  assign out_ch.popped_key     = out_popped_r[EW-1:PAYLOAD_WIDTH];
  assign out_ch.popped_payload = out_popped_r[PAYLOAD_WIDTH-1:0];
  assign out_ch.top_key        = out_top_r[EW-1:PAYLOAD_WIDTH];
  assign out_ch.top_payload    = out_top_r[PAYLOAD_WIDTH-1:0];
  assign out_ch.count          = out_count_r;
  assign out_ch.status         = out_status_r;

  // count never runs past the heap size
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above heap size");

  // every heap write lands inside the live region
  a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CW'(ram_waddr) < cnt_r))
    else $error("heap write beyond entry count");

  // a pop of a non-empty heap removes exactly one entry
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == bhpq_pkg::CMD_POP && cnt_r != '0)
      |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("pop did not decrement count");

  // a reported pop always carries an ok status
  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_popv_r) |-> (out_status_r == bhpq_pkg::STATUS_OK))
    else $error("popped entry with error status");

endmodule
